### hw/rtl/tcg_pkg.sv
package tcg_pkg;

    // Panel size in pixels and character cell geometry.
    localparam int DISPLAY_WIDTH    = 160;
    localparam int DISPLAY_HEIGHT   = 80;
    localparam int GLYPH_W          = 5;
    localparam int GLYPH_H          = 7;
    localparam int CELL_W           = 6;
    localparam int CELL_H           = 8;
    localparam int GLYPH_COUNT      = 59;
    localparam int PIXELS_PER_GLYPH = GLYPH_W * GLYPH_H;

    localparam int COORD_W     = 8;
    localparam int PIX_W       = 9;
    localparam int COLOR_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);

    // Cursor state lives in a single-entry memory.
    localparam int STATE_DEPTH  = 1;
    localparam int STATE_ADDR_W = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

    localparam logic [15:0] FG_COLOR_RESET      = 16'hFFFF;
    localparam logic [15:0] BG_COLOR_RESET      = 16'h0000;
    localparam logic [7:0]  COLUMN_OFFSET_RESET = 8'd1;
    localparam logic [7:0]  ROW_OFFSET_RESET    = 8'd26;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FG_COLOR      = 2'd0,
        REG_BG_COLOR      = 2'd1,
        REG_COLUMN_OFFSET = 2'd2,
        REG_ROW_OFFSET    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       new_string;
        logic [7:0] start_x;
        logic [7:0] start_y;
    } char_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_column;
        logic [PIX_W-1:0]   pixel_row;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } pixel_item_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [COLOR_W-1:0]     data;
    } cfg_item_t;

    typedef struct packed {
        logic               stopped;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] cursor_y;
        logic [COORD_W-1:0] cursor_x;
    } cursor_state_t;

    localparam int STATE_W = $bits(cursor_state_t);

    // Byte c of a glyph holds glyph column c; bit r of it is glyph row r.
    typedef logic [0:GLYPH_W-1][7:0] glyph_t;

    localparam glyph_t FONT_ROM [GLYPH_COUNT] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h4F,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h3E,8'h14,8'h3E,8'h14},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h07,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h3A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h10,8'h20,8'h7F},
        '{8'h41,8'h22,8'h1C,8'h22,8'h41}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43}
    };

    // Printable uppercase range maps straight in, lowercase folds to
    // uppercase, and everything else draws as a space.
    function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [7:0] code);
        logic [7:0] idx;
        idx = 8'h00;
        if (code >= 8'h20 && code <= 8'h5A)
        begin
            idx = code - 8'h20;
        end
        else if (code >= 8'h61 && code <= 8'h7A)
        begin
            idx = code - 8'h61 + (8'h41 - 8'h20);
        end
        return idx[GLYPH_IDX_W-1:0];
    endfunction

    function automatic glyph_t font_lookup(input logic [7:0] code);
        logic [GLYPH_IDX_W-1:0] gi;
        gi = glyph_index(code);
        if (int'(gi) >= GLYPH_COUNT)
        begin
            gi = '0;
        end
        return FONT_ROM[gi];
    endfunction

endpackage

### hw/rtl/tcg_chan_if.sv
interface tcg_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/text_char_generator_5x7.sv
// 5x7 text-mode character generator.
//
// The chars channel takes one character item: a character code, a
// new-string flag and the string origin. The block turns a drawable
// character into 35 pixel items on the pixels channel, glyph rows outer and
// columns inner, each with panel coordinates, an RGB565 color and a flag on
// the final pixel. The cfg channel writes the foreground and background
// colors and the panel offsets; it is always ready. It is to be written
// only while the block is idle; the block itself does not enforce this.
//
// The cursor state is kept in a single-entry synchronous memory. Each item
// is read from it, updated and written back before any pixel is produced,
// so the first pixel leaves the output register after FETCH and UPDATE.
// A drawn character occupies the block for one memory read, one update
// and one pixel per cycle out of the output register when the receiver
// never stalls. A character that draws nothing is done after the update.
//
// Reset restores the register defaults and marks the cursor memory empty,
// so its first read returns the all-zero cursor. When the receiver stalls,
// the output register holds its pixel and the pixel counter waits.
module text_char_generator_5x7
    import tcg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tcg_chan_if.sink   chars,
    tcg_chan_if.source pixels,
    tcg_chan_if.sink   cfg
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_DRAW   = 4'b1000
    } fsm_t;

    fsm_t fsm_reg;
    fsm_t fsm_next;

    // Configuration registers.
    logic [COLOR_W-1:0] fg_color_reg;
    logic [COLOR_W-1:0] bg_color_reg;
    logic [7:0]         column_offset_reg;
    logic [7:0]         row_offset_reg;

    // Accepted character and the glyph it selects.
    char_item_t item_reg;
    glyph_t     glyph_reg;

    // Cursor memory and the flag that says it has been written since reset.
    logic          state_valid_reg;
    logic          mem_we;
    logic          mem_re;
    logic [STATE_W-1:0] mem_rdata;
    cursor_state_t loaded_state;
    cursor_state_t start_state;
    cursor_state_t upd_state;
    logic          upd_draw;
    logic          wrap_hit;
    logic [COORD_W-1:0] wrap_x;
    logic [COORD_W-1:0] wrap_y;

    // Pixel walk.
    logic [PIX_W-1:0] x_base_reg;
    logic [PIX_W-1:0] y_base_reg;
    logic [2:0]       col_reg;
    logic [2:0]       row_reg;
    logic             last_in_glyph;
    logic             pix_load;

    pixel_item_t out_reg;
    logic        out_valid_reg;

    assign chars.ready    = (fsm_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign pixels.valid   = out_valid_reg;
    assign pixels.payload = out_reg;

    assign mem_re = chars.valid && chars.ready;
    assign mem_we = (fsm_reg == ST_UPDATE);

    tcg_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH),
        .ADDR_W(STATE_ADDR_W)
    ) u_state_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr('0),
        .wdata(upd_state),
        .re   (mem_re),
        .raddr('0),
        .rdata(mem_rdata)
    );

    // Until the first write-back the memory content is meaningless and the
    // cursor reads as its reset value of all zeros.
    assign loaded_state = state_valid_reg ? cursor_state_t'(mem_rdata) : '0;

    // Cursor update: a new string reloads the origin first, then the line
    // wrap and bottom-of-panel stop are checked, then the fit of the glyph.
    always_comb
    begin
        start_state = loaded_state;
        if (item_reg.new_string)
        begin
            start_state.origin_x = item_reg.start_x;
            start_state.cursor_x = item_reg.start_x;
            start_state.cursor_y = item_reg.start_y;
            start_state.stopped  = 1'b0;
        end

        upd_state = start_state;
        upd_draw  = 1'b0;
        wrap_hit  = 1'b0;
        wrap_x    = start_state.cursor_x;
        wrap_y    = start_state.cursor_y;

        if (!start_state.stopped)
        begin
            wrap_hit = ({1'b0, start_state.cursor_x} + 9'(CELL_W) > 9'(DISPLAY_WIDTH));
            if (wrap_hit)
            begin
                wrap_x = start_state.origin_x;
                wrap_y = start_state.cursor_y + 8'(CELL_H);
            end
            upd_state.cursor_y = wrap_y;
            if (wrap_hit && ({1'b0, wrap_y} + 9'(CELL_H) > 9'(DISPLAY_HEIGHT)))
            begin
                // A wrap past the bottom of the panel drops the rest of the string.
                upd_state.cursor_x = wrap_x;
                upd_state.stopped  = 1'b1;
            end
            else
            begin
                upd_draw = ({1'b0, wrap_x} + 9'(GLYPH_W) <= 9'(DISPLAY_WIDTH)) &&
                           ({1'b0, wrap_y} + 9'(GLYPH_H) <= 9'(DISPLAY_HEIGHT));
                upd_state.cursor_x = wrap_x + 8'(CELL_W);
            end
        end
    end

    assign last_in_glyph = (row_reg == 3'(GLYPH_H - 1)) && (col_reg == 3'(GLYPH_W - 1));
    assign pix_load      = (fsm_reg == ST_DRAW) && (!out_valid_reg || pixels.ready);

    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            ST_IDLE:
            begin
                if (chars.valid)
                begin
                    fsm_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                fsm_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                fsm_next = upd_draw ? ST_DRAW : ST_IDLE;
            end
            ST_DRAW:
            begin
                if (pix_load && last_in_glyph)
                begin
                    fsm_next = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg           <= ST_IDLE;
            state_valid_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            fg_color_reg      <= FG_COLOR_RESET;
            bg_color_reg      <= BG_COLOR_RESET;
            column_offset_reg <= COLUMN_OFFSET_RESET;
            row_offset_reg    <= ROW_OFFSET_RESET;
            col_reg           <= '0;
            row_reg           <= '0;
        end
        else
        begin
            fsm_reg <= fsm_next;

            if (mem_we)
            begin
                state_valid_reg <= 1'b1;
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.payload.index)
                    REG_FG_COLOR:      fg_color_reg      <= cfg.payload.data;
                    REG_BG_COLOR:      bg_color_reg      <= cfg.payload.data;
                    REG_COLUMN_OFFSET: column_offset_reg <= cfg.payload.data[7:0];
                    REG_ROW_OFFSET:    row_offset_reg    <= cfg.payload.data[7:0];
                    default:           fg_color_reg      <= fg_color_reg;
                endcase
            end

            if (fsm_reg == ST_UPDATE)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (pix_load)
            begin
                if (col_reg == 3'(GLYPH_W - 1))
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 3'd1;
                end
                else
                begin
                    col_reg <= col_reg + 3'd1;
                end
            end

            if (pix_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixels.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            item_reg <= chars.payload;
        end
        if (fsm_reg == ST_UPDATE)
        begin
            glyph_reg  <= font_lookup(item_reg.char_code);
            x_base_reg <= 9'(wrap_x) + 9'(column_offset_reg);
            y_base_reg <= 9'(wrap_y) + 9'(row_offset_reg);
        end
        if (pix_load)
        begin
            out_reg.pixel_column <= x_base_reg + 9'(col_reg);
            out_reg.pixel_row    <= y_base_reg + 9'(row_reg);
            out_reg.pixel_color  <= glyph_reg[col_reg][row_reg] ? fg_color_reg
                                                                : bg_color_reg;
            out_reg.last_pixel   <= last_in_glyph;
        end
    end

endmodule

### hw/rtl/tcg_ram.sv
module tcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hw/rtl/tcg_checker.sv
module tcg_checker
    import tcg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        chars_valid,
    input logic        chars_ready,
    input logic        pixels_valid,
    input logic        pixels_ready,
    input pixel_item_t pixels_payload
);

    // One character at a time: the block is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid && chars_ready |=> !chars_ready)
        else $error("character accepted back to back");

    // No character is taken while a glyph is still being drawn.
    a_no_accept_mid_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        pixels_valid && !pixels_payload.last_pixel |-> !chars_ready)
        else $error("character accepted in the middle of a glyph");

    // A stalled pixel holds.
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixels_valid && !pixels_ready |=> pixels_valid && $stable(pixels_payload))
        else $error("stalled pixel changed");

endmodule

bind text_char_generator_5x7 tcg_checker u_tcg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .chars_valid   (chars.valid),
    .chars_ready   (chars.ready),
    .pixels_valid  (pixels.valid),
    .pixels_ready  (pixels.ready),
    .pixels_payload(pixels.payload)
);
